/* hw/rtl/gbts_pkg.sv */
// Shared constants, codes and control types of the gap buffer text store.
`default_nettype none
package gbts_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = 13;
   localparam int CHAR_W   = 8;
   localparam int OP_W     = 2;
   localparam int STS_W    = 2;

   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

   localparam logic [OP_W-1:0] OP_READ   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

   typedef struct packed {
      logic load_req;
      logic eval;
      logic read_issue;
      logic capture;
      logic start_move;
      logic move_step;
      logic apply;
      logic load_rsp;
   } gbts_cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_clear;
      logic fail;
      logic noop;
      logic need_move;
      logic move_done;
      logic out_free;
   } gbts_stat_type;

endpackage
`default_nettype wire

/* hw/rtl/gbts_req_if.sv */
// Request channel: valid/ready handshake with the operation word.
`default_nettype none
interface gbts_req_if
   import gbts_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [POS_W-1:0]  position;
   logic [POS_W-1:0]  end_position;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, op, position, end_position, char_in, input ready);
   modport sink (input valid, op, position, end_position, char_in, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gbts_rsp_if.sv */
// Response channel: valid/ready handshake with the result word.
`default_nettype none
interface gbts_rsp_if
   import gbts_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic [POS_W-1:0]  text_length;
   logic [STS_W-1:0]  status;

   modport source (output valid, char_out, text_length, status, input ready);
   modport sink (input valid, char_out, text_length, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gbts_datapath.sv */
// Datapath: byte store, gap pointers, gap move copier and response register.
`default_nettype none
module gbts_datapath
   import gbts_pkg::*;
   (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gbts_cmd_type      cmd,
   output gbts_stat_type          stat,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [POS_W-1:0]  req_end_position,
   input  wire logic [CHAR_W-1:0] req_char_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic [POS_W-1:0]       rsp_text_length,
   output logic [STS_W-1:0]       rsp_status
   );

   logic [CHAR_W-1:0] mem [CAPACITY];

   logic [OP_W-1:0]   op_ff;
   logic [POS_W-1:0]  pos_ff, endp_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [POS_W-1:0]  gf_ff, gf_in, gl_ff, gl_in;
   logic [STS_W-1:0]  status_ff, status_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [POS_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic              fwd_ff, fwd_in;
   logic [POS_W-1:0]  src_ff, src_in, dst_ff, dst_in;
   logic [ADDR_W-1:0] dst_pend_ff, dst_pend_in;
   logic [CHAR_W-1:0] rdata_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [POS_W-1:0]  rsp_len_ff;
   logic [STS_W-1:0]  rsp_status_ff;

   logic [POS_W-1:0]  gsize, len, read_idx;
   logic              rd_err, ins_err, del_err, full;
   logic [ADDR_W-1:0] raddr, waddr;
   logic [CHAR_W-1:0] wdata;
   logic              we;

   assign gsize    = gl_ff - gf_ff;
   assign len      = CAP_POS - gsize;
   assign rd_err   = pos_ff >= len;
   assign ins_err  = pos_ff > len;
   assign del_err  = (pos_ff > endp_ff) || (endp_ff > len);
   assign full     = gsize == '0;
   assign read_idx = (pos_ff < gf_ff) ? pos_ff : pos_ff + gsize;

   always_comb begin
      stat.is_read   = op_ff == OP_READ;
      stat.is_clear  = op_ff == OP_CLEAR;
      stat.noop      = (op_ff == OP_DELETE) && (pos_ff == endp_ff);
      stat.need_move = pos_ff != gf_ff;
      stat.move_done = (cnt_ff == '0) && !pend_ff;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
      case (op_ff)
         OP_READ:   begin
            stat.fail = rd_err;
            status_in = rd_err ? STS_RANGE : STS_OK;
         end
         OP_INSERT: begin
            stat.fail = ins_err || full;
            status_in = ins_err ? STS_RANGE : (full ? STS_FULL : STS_OK);
         end
         OP_DELETE: begin
            stat.fail = del_err;
            status_in = del_err ? STS_RANGE : STS_OK;
         end
         default:   begin
            stat.fail = 1'b0;
            status_in = STS_OK;
         end
      endcase
   end

   // Store ports: one registered read, one write per cycle.
   always_comb begin
      raddr = cmd.read_issue ? read_idx[ADDR_W-1:0] : src_ff[ADDR_W-1:0];
      we    = 1'b0;
      waddr = dst_pend_ff;
      wdata = rdata_ff;
      if (pend_ff) begin
         we = 1'b1;
      end else if (cmd.apply && (op_ff == OP_INSERT)) begin
         we    = 1'b1;
         waddr = pos_ff[ADDR_W-1:0];
         wdata = ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      gf_in        = gf_ff;
      gl_in        = gl_ff;
      char_in      = char_ff;
      cnt_in       = cnt_ff;
      fwd_in       = fwd_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pend_in      = 1'b0;
      dst_pend_in  = dst_pend_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.eval) begin
         char_in = '0;
      end
      if (cmd.capture) begin
         char_in = rdata_ff;
      end
      if (cmd.start_move) begin
         fwd_in = pos_ff > gf_ff;
         if (pos_ff > gf_ff) begin
            cnt_in = pos_ff - gf_ff;
            src_in = gl_ff;
            dst_in = gf_ff;
         end else begin
            cnt_in = gf_ff - pos_ff;
            src_in = gf_ff - POS_W'(1);
            dst_in = gl_ff - POS_W'(1);
         end
      end
      if (cmd.move_step && (cnt_ff != '0)) begin
         pend_in     = 1'b1;
         dst_pend_in = dst_ff[ADDR_W-1:0];
         cnt_in      = cnt_ff - POS_W'(1);
         src_in      = fwd_ff ? src_ff + POS_W'(1) : src_ff - POS_W'(1);
         dst_in      = fwd_ff ? dst_ff + POS_W'(1) : dst_ff - POS_W'(1);
      end
      if (cmd.apply) begin
         case (op_ff)
            OP_INSERT: begin
               gf_in = pos_ff + POS_W'(1);
               gl_in = pos_ff + gsize;
            end
            OP_DELETE: begin
               gf_in = pos_ff;
               gl_in = endp_ff + gsize;
            end
            OP_CLEAR:  begin
               gf_in = '0;
               gl_in = CAP_POS;
            end
            default:   begin
               gf_in = gf_ff;
               gl_in = gl_ff;
            end
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gf_ff        <= '0;
         gl_ff        <= CAP_POS;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gf_ff        <= gf_in;
         gl_ff        <= gl_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fwd_ff      <= fwd_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      dst_pend_ff <= dst_pend_in;
      char_ff     <= char_in;
      if (cmd.load_req) begin
         op_ff   <= req_op;
         pos_ff  <= req_position;
         endp_ff <= req_end_position;
         ch_ff   <= req_char_in;
      end
      if (cmd.eval) begin
         status_ff <= status_in;
      end
      if (cmd.load_rsp) begin
         rsp_char_ff   <= char_ff;
         rsp_len_ff    <= len;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_text_length = rsp_len_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
`default_nettype wire

/* hw/rtl/gbts_ctrl.sv */
// Controller: sequences evaluate, gap move, apply and response per word.
`default_nettype none
module gbts_ctrl
   import gbts_pkg::*;
   (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire gbts_stat_type stat,
   output gbts_cmd_type       cmd
   );

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EVAL  = 5'b00010,
      S_MOVE  = 5'b00100,
      S_RWAIT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE:  begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL:  begin
            cmd.eval = 1'b1;
            if (stat.is_clear) begin
               cmd.apply = 1'b1;
               state_in  = S_DONE;
            end else if (stat.fail || stat.noop) begin
               state_in = S_DONE;
            end else if (stat.is_read) begin
               cmd.read_issue = 1'b1;
               state_in       = S_RWAIT;
            end else if (stat.need_move) begin
               cmd.start_move = 1'b1;
               state_in       = S_MOVE;
            end else begin
               cmd.apply = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_MOVE:  begin
            cmd.move_step = 1'b1;
            if (stat.move_done) begin
               cmd.apply = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_RWAIT: begin
            cmd.capture = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE:  begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/gap_buffer_text_store.sv */
// Top level of the gap buffer text store: controller plus datapath.
//
//   channel  dir  word
//   req_ch   in   op, position, end_position, char_in
//   rsp_ch   out  char_out, text_length, status
//
// One word at a time. Insert and delete away from the gap start first run the
// gap copy loop, which moves |position - gap start| bytes, one byte per cycle
// through the store port.
// Reset is synchronous and empties the buffer; the byte store is not cleared.
// A response waits in the output register while the next word is accepted.
`default_nettype none
module gap_buffer_text_store
   import gbts_pkg::*;
   (
   input wire logic   clock,
   input wire logic   reset,
   gbts_req_if.sink   req_ch,
   gbts_rsp_if.source rsp_ch
   );

   gbts_cmd_type  cmd;
   gbts_stat_type stat;

   gbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gbts_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_ch.op),
      .req_position     (req_ch.position),
      .req_end_position (req_ch.end_position),
      .req_char_in      (req_ch.char_in),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_char_out     (rsp_ch.char_out),
      .rsp_text_length  (rsp_ch.text_length),
      .rsp_status       (rsp_ch.status)
   );

endmodule
`default_nettype wire

/* test/gbts_checker.sv */
// Checker for the gap buffer text store: tracks the text and compares every response word.
module gbts_checker
   import gbts_pkg::*;
   (
   input wire logic clock,
   input wire logic reset,
   gbts_req_if      req_mon,
   gbts_rsp_if      rsp_mon,
   output int       errors,
   output int       pending
   );

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic [POS_W-1:0]  text_length;
      logic [STS_W-1:0]  status;
   } reply_type;

   logic [CHAR_W-1:0] text_mem [CAPACITY];
   int unsigned       gap_lo;
   int unsigned       gap_hi;
   reply_type         reply_q [$];

   function automatic int unsigned text_len();
      return CAPACITY - (gap_hi - gap_lo);
   endfunction

   // byte-by-byte gap move, same order as the hardware copy loop
   function automatic void move_gap_to(input int unsigned target);
      int unsigned gsize;
      gsize = gap_hi - gap_lo;
      if (target > gap_lo) begin
         for (int unsigned i = 0; i < target - gap_lo; i++)
            text_mem[gap_lo + i] = text_mem[gap_hi + i];
      end else if (target < gap_lo) begin
         for (int unsigned i = gap_lo - target; i > 0; i--)
            text_mem[target + gsize + i - 1] = text_mem[target + i - 1];
      end
      gap_lo = target;
      gap_hi = target + gsize;
   endfunction

   function automatic reply_type edit_text(input logic [OP_W-1:0] op,
                                           input logic [POS_W-1:0] position,
                                           input logic [POS_W-1:0] end_position,
                                           input logic [CHAR_W-1:0] char_in);
      int unsigned len;
      int unsigned p;
      int unsigned e;
      reply_type   r;
      len = text_len();
      p = position;
      e = end_position;
      r.char_out = '0;
      r.status = STS_OK;
      case (op)
         OP_READ: begin
            if (p >= len)
               r.status = STS_RANGE;
            else
               r.char_out = text_mem[(p < gap_lo) ? p : p + gap_hi - gap_lo];
         end
         OP_INSERT: begin
            if (p > len) begin
               r.status = STS_RANGE;
            end else if (gap_hi == gap_lo) begin
               r.status = STS_FULL;
            end else begin
               if (p != gap_lo) move_gap_to(p);
               text_mem[gap_lo] = char_in;
               gap_lo++;
            end
         end
         OP_DELETE: begin
            if (p > e || e > len) begin
               r.status = STS_RANGE;
            end else if (p != e) begin
               if (p != gap_lo) move_gap_to(p);
               gap_hi += e - p;
            end
         end
         default: begin
            gap_lo = 0;
            gap_hi = CAPACITY;
         end
      endcase
      r.text_length = POS_W'(text_len());
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (errors < 50)
         $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         gap_lo = 0;
         gap_hi = CAPACITY;
         reply_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_q.size() == 0) begin
               report_mismatch("unrequested word status", rsp_mon.status, 0);
            end else begin
               want = reply_q.pop_front();
               if (rsp_mon.char_out !== want.char_out)
                  report_mismatch("char_out", rsp_mon.char_out, want.char_out);
               if (rsp_mon.text_length !== want.text_length)
                  report_mismatch("text_length", rsp_mon.text_length, want.text_length);
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
            end
         end
         if (req_mon.valid && req_mon.ready)
            reply_q.push_back(edit_text(req_mon.op, req_mon.position,
                                        req_mon.end_position, req_mon.char_in));
      end
      pending <= reply_q.size();
   end

endmodule

/* test/testbench.sv */
// Top of the gap buffer text store testbench: clock, reset, stimulus and verdict.
module testbench;
   import gbts_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_WORDS = 1100;
   localparam int DRAIN_CYCLES = 32;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          pending_words;
   int          idle_cycles;
   int unsigned est_len;
   int unsigned cursor;
   bit          calm_sender;

   gbts_req_if req_ch ();
   gbts_rsp_if rsp_ch ();

   gap_buffer_text_store DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gbts_checker CHK (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_ch),
      .rsp_mon (rsp_ch),
      .errors  (fail_count),
      .pending (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_sender) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // edits mostly land close to the last edit, so the gap moves only a little
   function automatic int unsigned near_cursor(input int unsigned hi);
      int p;
      if ($urandom_range(0, 99) < 15) return $urandom_range(0, hi);
      p = int'(cursor) + int'($urandom_range(0, 12)) - 6;
      if (p < 0) p = 0;
      if (p > int'(hi)) p = hi;
      return p;
   endfunction

   task automatic send_word(input logic [OP_W-1:0] op, input int unsigned pos,
                            input int unsigned endp, input int unsigned ch);
      int unsigned gap;
      logic [POS_W-1:0] p_bits;
      logic [POS_W-1:0] e_bits;
      logic [CHAR_W-1:0] c_bits;
      gap = pick_gap();
      p_bits = (op == OP_CLEAR) ? POS_W'($urandom_range(0, 8191)) : POS_W'(pos);
      e_bits = (op == OP_DELETE) ? POS_W'(endp) : POS_W'($urandom_range(0, 8191));
      c_bits = (op == OP_INSERT) ? CHAR_W'(ch) : CHAR_W'($urandom_range(0, 255));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.position     <= p_bits;
      req_ch.end_position <= e_bits;
      req_ch.char_in      <= c_bits;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      case (op)
         OP_INSERT: begin
            if (p_bits <= est_len && est_len < CAPACITY) begin
               est_len++;
               cursor = p_bits + 1;
            end
         end
         OP_DELETE: begin
            if (p_bits <= e_bits && e_bits <= est_len && p_bits != e_bits) begin
               est_len -= e_bits - p_bits;
               cursor = p_bits;
            end
         end
         OP_CLEAR: begin
            est_len = 0;
            cursor = 0;
         end
         default: ;
      endcase
   endtask

   // hold the sender off until every response is back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned r;
      int unsigned pos;
      int unsigned span;
      req_ch.valid = 1'b0;
      req_ch.op = OP_READ;
      req_ch.position = '0;
      req_ch.end_position = '0;
      req_ch.char_in = '0;
      reset = 1'b1;
      est_len = 0;
      cursor = 0;
      calm_sender = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed edits on a short text
      send_word(OP_READ, 0, 0, 0);
      send_word(OP_READ, 8191, 0, 0);
      send_word(OP_DELETE, 0, 0, 0);
      send_word(OP_INSERT, 1, 0, 8'h77);
      send_word(OP_INSERT, 0, 0, 8'h00);
      send_word(OP_INSERT, 1, 0, 8'hFF);
      send_word(OP_INSERT, 0, 0, 8'hA5);
      send_word(OP_INSERT, 3, 0, 8'h3C);
      send_word(OP_READ, 0, 0, 0);
      send_word(OP_READ, 3, 0, 0);
      send_word(OP_READ, 4, 0, 0);
      send_word(OP_DELETE, 1, 1, 0);
      send_word(OP_DELETE, 2, 1, 0);
      send_word(OP_DELETE, 0, 5, 0);
      send_word(OP_DELETE, 1, 3, 0);
      send_word(OP_READ, 1, 0, 0);
      send_word(OP_DELETE, 0, 8191, 0);
      send_word(OP_INSERT, 8191, 0, 8'h42);
      send_word(OP_INSERT, 2, 0, 8'h7E);
      send_word(OP_CLEAR, 0, 0, 0);
      send_word(OP_READ, 0, 0, 0);
      send_word(OP_INSERT, 0, 0, 8'h5A);
      send_word(OP_READ, 0, 0, 0);

      // positions at and beyond the capacity
      send_word(OP_CLEAR, 0, 0, 0);
      send_word(OP_INSERT, CAPACITY, 0, 8'h11);
      send_word(OP_INSERT, 0, 0, 8'h22);
      send_word(OP_INSERT, CAPACITY + 1, 0, 8'h33);
      send_word(OP_READ, CAPACITY - 1, 0, 0);
      send_word(OP_READ, CAPACITY, 0, 0);
      send_word(OP_READ, 0, 0, 0);
      send_word(OP_DELETE, CAPACITY - 1, CAPACITY + 1, 0);
      send_word(OP_DELETE, CAPACITY, CAPACITY, 0);
      send_word(OP_DELETE, 0, CAPACITY, 0);
      send_word(OP_READ, 0, 0, 0);
      settle();

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         calm_sender = ((k / 100) % 4 == 1);
         if (k == RANDOM_WORDS / 2) settle();
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_word(OP_W'($urandom_range(OP_READ, OP_CLEAR)), $urandom_range(0, 8191),
                      $urandom_range(0, 8191), $urandom_range(0, 255));
         end else if (r < 10) begin
            send_word(OP_CLEAR, 0, 0, 0);
         end else if (r < 42) begin
            send_word(OP_READ, (est_len == 0) ? 0 : near_cursor(est_len - 1), 0, 0);
         end else if ((r < 75 && est_len < 700) || est_len < 40) begin
            send_word(OP_INSERT, near_cursor(est_len), 0, $urandom_range(0, 255));
         end else begin
            pos = near_cursor(est_len);
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 4);
            send_word(OP_DELETE, pos, (pos + span > est_len) ? est_len : pos + span, 0);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      int unsigned stall;
      int unsigned cyc;
      int unsigned r;
      rsp_ch.ready = 1'b0;
      stall = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if ((cyc / 600) % 4 == 2) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
